[design/mse_pkg.sv]
// mse_pkg: shared types and codes for the mips subset executor
// item structs, event codes, instruction field codes, register indexes
// no dependencies
package mse_pkg;

    localparam int RF_DEPTH  = 32;
    localparam int RF_WIDTH  = 32;
    localparam int RF_ADDR_W = 5;

    localparam logic ITEM_START = 1'b0;
    localparam logic ITEM_EXEC  = 1'b1;

    localparam logic CFG_ENTRY  = 1'b0;
    localparam logic CFG_LENGTH = 1'b1;

    localparam logic [2:0] EV_NONE        = 3'd0;
    localparam logic [2:0] EV_PRINT_INT   = 3'd1;
    localparam logic [2:0] EV_PRINT_CHAR  = 3'd2;
    localparam logic [2:0] EV_EXIT        = 3'd3;
    localparam logic [2:0] EV_BAD_SYSCALL = 3'd4;
    localparam logic [2:0] EV_BAD_INSTR   = 3'd5;
    localparam logic [2:0] EV_PAST_END    = 3'd6;
    localparam logic [2:0] EV_HALTED      = 3'd7;

    localparam logic [5:0] OP_RTYPE   = 6'h00;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_ORI     = 6'h0D;
    localparam logic [5:0] OP_LUI     = 6'h0F;
    localparam logic [5:0] FN_SYSCALL = 6'h0C;
    localparam logic [5:0] FN_ADD     = 6'h20;

    localparam logic [31:0] SYS_PRINT_INT  = 32'd1;
    localparam logic [31:0] SYS_EXIT       = 32'd10;
    localparam logic [31:0] SYS_PRINT_CHAR = 32'd11;

    localparam logic [RF_ADDR_W-1:0] REG_ZERO = 5'd0;
    localparam logic [RF_ADDR_W-1:0] REG_V0   = 5'd2;
    localparam logic [RF_ADDR_W-1:0] REG_A0   = 5'd4;

    typedef struct packed {
        logic        opcode;
        logic [31:0] instruction_word;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         event_res;
        logic signed [31:0] event_value;
        logic [31:0]        counter_out;
    } out_item_t;

endpackage

[design/mips_subset_executor.sv]
// mips_subset_executor: a result passes the ram read stage, then the output register;
// throughput one item per cycle while m_ready does not stall the output
// register file lives in two mirrored 32x32 rams, the previous write is forwarded
// aresetn (sync, active low) zeroes counter and config, sets halt, empties pipe
// a per-register valid bit makes unwritten registers read zero; start clears them
// depends on mse_pkg and mse_ram
module mips_subset_executor
    import mse_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_payload,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_payload,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int RF_W = RF_WIDTH;
    localparam int RF_N = RF_DEPTH;
    localparam int AW   = RF_ADDR_W;

    logic              s_fire;
    logic              s1_go;
    logic              s1_fire;
    logic              cfg_wr;
    logic [5:0]        s_op;
    logic [5:0]        s_fn;
    logic              s_is_sys;
    logic [AW-1:0]     s_a_addr;
    logic [AW-1:0]     s_b_addr;

    logic              s1_valid_reg;
    logic              s1_op_reg;
    logic [31:0]       s1_word_reg;
    logic [AW-1:0]     s1_a_addr_reg;
    logic [AW-1:0]     s1_b_addr_reg;

    logic              m_valid_reg;
    out_item_t         m_payload_reg;
    out_item_t         res;

    logic [31:0]       entry_reg;
    logic [31:0]       length_reg;
    logic [31:0]       pc_reg;
    logic [31:0]       pc_next;
    logic              halted_reg;
    logic              halted_next;
    logic [RF_N-1:0]   rf_valid_reg;
    logic [RF_N-1:0]   rf_valid_next;
    logic              wb_valid_reg;
    logic [AW-1:0]     wb_addr_reg;
    logic [RF_W-1:0]   wb_data_reg;

    logic [RF_W-1:0]   ram_a_data;
    logic [RF_W-1:0]   ram_b_data;
    logic [31:0]       opa;
    logic [31:0]       opb;

    logic [5:0]        op;
    logic [5:0]        fn;
    logic [AW-1:0]     rs_rt;
    logic [AW-1:0]     rd;
    logic [15:0]       imm;
    logic              wr_req;
    logic              rf_we;
    logic [AW-1:0]     rf_waddr;
    logic [RF_W-1:0]   rf_wdata;
    logic [2:0]        ev;
    logic [31:0]       val;

    // handshake
    assign s1_go   = !m_valid_reg || m_ready;
    assign s_ready = !s1_valid_reg || s1_go;
    assign s_fire  = s_valid && s_ready;
    assign s1_fire = s1_valid_reg && s1_go;
    assign m_valid = m_valid_reg;
    assign m_payload = m_payload_reg;

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == CFG_LENGTH) ? length_reg : entry_reg;

    // read address select at acceptance
    assign s_op     = s_payload.instruction_word[31:26];
    assign s_fn     = s_payload.instruction_word[5:0];
    assign s_is_sys = (s_op == OP_RTYPE) && (s_fn == FN_SYSCALL);
    assign s_a_addr = s_is_sys ? REG_V0 : s_payload.instruction_word[25:21];
    assign s_b_addr = s_is_sys ? REG_A0 : s_payload.instruction_word[20:16];

    mse_ram #(.WIDTH(RF_W), .DEPTH(RF_N)) u_rf_a (
        .aclk    (aclk),
        .wr_en   (s1_fire && rf_we),
        .wr_addr (rf_waddr),
        .wr_data (rf_wdata),
        .rd_en   (s_fire),
        .rd_addr (s_a_addr),
        .rd_data (ram_a_data)
    );

    mse_ram #(.WIDTH(RF_W), .DEPTH(RF_N)) u_rf_b (
        .aclk    (aclk),
        .wr_en   (s1_fire && rf_we),
        .wr_addr (rf_waddr),
        .wr_data (rf_wdata),
        .rd_en   (s_fire),
        .rd_addr (s_b_addr),
        .rd_data (ram_b_data)
    );

    // operand fetch with forwarding of the last write
    always_comb begin
        if (wb_valid_reg && (wb_addr_reg == s1_a_addr_reg)) begin
            opa = wb_data_reg;
        end else if (rf_valid_reg[s1_a_addr_reg]) begin
            opa = ram_a_data;
        end else begin
            opa = '0;
        end
        if (wb_valid_reg && (wb_addr_reg == s1_b_addr_reg)) begin
            opb = wb_data_reg;
        end else if (rf_valid_reg[s1_b_addr_reg]) begin
            opb = ram_b_data;
        end else begin
            opb = '0;
        end
    end

    assign op    = s1_word_reg[31:26];
    assign fn    = s1_word_reg[5:0];
    assign rs_rt = s1_word_reg[20:16];
    assign rd    = s1_word_reg[15:11];
    assign imm   = s1_word_reg[15:0];

    // execute
    always_comb begin
        pc_next       = pc_reg;
        halted_next   = halted_reg;
        rf_valid_next = rf_valid_reg;
        wr_req        = 1'b0;
        rf_waddr      = rs_rt;
        rf_wdata      = '0;
        ev            = EV_NONE;
        val           = '0;
        if (s1_op_reg == ITEM_START) begin
            pc_next       = entry_reg;
            halted_next   = entry_reg >= length_reg;
            rf_valid_next = '0;
            ev            = (entry_reg >= length_reg) ? EV_PAST_END : EV_NONE;
        end else if (halted_reg) begin
            ev = EV_HALTED;
        end else begin
            pc_next = pc_reg + 32'd1;
            case (op)
                OP_RTYPE: begin
                    case (fn)
                        FN_ADD: begin
                            wr_req   = 1'b1;
                            rf_waddr = rd;
                            rf_wdata = opa + opb;
                        end
                        FN_SYSCALL: begin
                            if (opa == SYS_PRINT_INT) begin
                                ev  = EV_PRINT_INT;
                                val = opb;
                            end else if (opa == SYS_EXIT) begin
                                ev = EV_EXIT;
                            end else if (opa == SYS_PRINT_CHAR) begin
                                ev  = EV_PRINT_CHAR;
                                val = {24'd0, opb[7:0]};
                            end else begin
                                ev = EV_BAD_SYSCALL;
                            end
                        end
                        default: begin
                            ev  = EV_BAD_INSTR;
                            val = s1_word_reg;
                        end
                    endcase
                end
                OP_ADDI: begin
                    wr_req   = 1'b1;
                    rf_wdata = opa + {{16{imm[15]}}, imm};
                end
                OP_ORI: begin
                    wr_req   = 1'b1;
                    rf_wdata = opa | {16'd0, imm};
                end
                OP_LUI: begin
                    wr_req   = 1'b1;
                    rf_wdata = {imm, 16'd0};
                end
                default: begin
                    ev  = EV_BAD_INSTR;
                    val = s1_word_reg;
                end
            endcase
            if (ev == EV_EXIT || ev == EV_BAD_SYSCALL || ev == EV_BAD_INSTR) begin
                halted_next = 1'b1;
            end else if (pc_next >= length_reg) begin
                halted_next = 1'b1;
                if (ev == EV_NONE) begin
                    ev = EV_PAST_END;
                end
            end
        end
        rf_we = wr_req && (rf_waddr != REG_ZERO);
        if (rf_we) begin
            rf_valid_next[rf_waddr] = 1'b1;
        end
        res.event_res   = ev;
        res.event_value = $signed(val);
        res.counter_out = pc_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            entry_reg    <= '0;
            length_reg   <= '0;
            pc_reg       <= '0;
            halted_reg   <= 1'b1;
            rf_valid_reg <= '0;
            wb_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr) begin
                if (paddr[2] == CFG_LENGTH) begin
                    length_reg <= pwdata;
                end else begin
                    entry_reg <= pwdata;
                end
            end
            if (s_ready) begin
                s1_valid_reg <= s_valid;
            end
            if (s1_go) begin
                m_valid_reg <= s1_valid_reg;
            end
            if (s1_fire) begin
                pc_reg       <= pc_next;
                halted_reg   <= halted_next;
                rf_valid_reg <= rf_valid_next;
                wb_valid_reg <= rf_we;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_op_reg     <= s_payload.opcode;
            s1_word_reg   <= s_payload.instruction_word;
            s1_a_addr_reg <= s_a_addr;
            s1_b_addr_reg <= s_b_addr;
        end
        if (s1_fire) begin
            m_payload_reg <= res;
            wb_addr_reg   <= rf_waddr;
            wb_data_reg   <= rf_wdata;
        end
    end

`ifndef SYNTH
    a_no_zero_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_fire && rf_we) |-> (rf_waddr != REG_ZERO))
        else $error("write to register zero");

    a_halted_event: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_fire && (s1_op_reg == ITEM_EXEC) && halted_reg)
        |=> (m_payload.event_res == EV_HALTED))
        else $error("item while halted did not report halted");

    a_start_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_fire && (s1_op_reg == ITEM_START)) |=> (rf_valid_reg == '0 && !wb_valid_reg))
        else $error("start item did not clear register file");

    a_halt_persists: assert property (@(posedge aclk) disable iff (!aresetn)
        (halted_reg && !(s1_fire && (s1_op_reg == ITEM_START))) |=> halted_reg)
        else $error("halt released without start item");
`endif

endmodule

[design/mse_ram.sv]
// mse_ram: generic single-write, single-read synchronous ram
// registered read; no dependencies
module mse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[test/mips_subset_executor_test.sv]
// mips_subset_executor_test: self-checking bench for the mips subset executor
// predicts each event from its own register file, counter and halt model
// depends on mse_pkg and the mips_subset_executor rtl
module mips_subset_executor_test;
    import mse_pkg::*;

    class event_scoreboard;
        logic [31:0] gpr [RF_DEPTH];
        logic [31:0] pc;
        bit          halted;
        logic [31:0] entry_addr;
        logic [31:0] prog_len;
        out_item_t   pending_events [$];
        int          mismatches;

        function new();
            foreach (gpr[i]) gpr[i] = '0;
            pc         = '0;
            halted     = 1'b1;
            entry_addr = '0;
            prog_len   = '0;
            mismatches = 0;
        endfunction

        function void write_cfg(logic idx, logic [31:0] value);
            if (idx == CFG_ENTRY) begin
                entry_addr = value;
            end else begin
                prog_len = value;
            end
        endfunction

        function logic [2:0] note_item(in_item_t it);
            out_item_t   exp;
            logic [31:0] w;
            logic [31:0] simm;
            logic [31:0] num;
            logic [5:0]  op;
            logic [5:0]  fn;
            logic [4:0]  rs;
            logic [4:0]  rt;
            logic [4:0]  rd;
            logic [2:0]  ev;
            logic [31:0] val;
            ev  = EV_NONE;
            val = '0;
            if (it.opcode == ITEM_START) begin
                foreach (gpr[i]) gpr[i] = '0;
                pc     = entry_addr;
                halted = 1'b0;
                if (pc >= prog_len) begin
                    halted = 1'b1;
                    ev     = EV_PAST_END;
                end
            end else if (halted) begin
                ev = EV_HALTED;
            end else begin
                w    = it.instruction_word;
                op   = w[31:26];
                rs   = w[25:21];
                rt   = w[20:16];
                rd   = w[15:11];
                fn   = w[5:0];
                simm = {{16{w[15]}}, w[15:0]};
                pc   = pc + 32'd1;
                case (op)
                    OP_RTYPE: begin
                        if (fn == FN_ADD) begin
                            gpr[rd] = gpr[rs] + gpr[rt];
                        end else if (fn == FN_SYSCALL) begin
                            num = gpr[REG_V0];
                            if (num == SYS_PRINT_INT) begin
                                ev  = EV_PRINT_INT;
                                val = gpr[REG_A0];
                            end else if (num == SYS_EXIT) begin
                                ev = EV_EXIT;
                            end else if (num == SYS_PRINT_CHAR) begin
                                ev  = EV_PRINT_CHAR;
                                val = {24'h0, gpr[REG_A0][7:0]};
                            end else begin
                                ev = EV_BAD_SYSCALL;
                            end
                        end else begin
                            ev  = EV_BAD_INSTR;
                            val = w;
                        end
                    end
                    OP_ADDI: gpr[rt] = gpr[rs] + simm;
                    OP_ORI:  gpr[rt] = gpr[rs] | {16'h0, w[15:0]};
                    OP_LUI:  gpr[rt] = {w[15:0], 16'h0};
                    default: begin
                        ev  = EV_BAD_INSTR;
                        val = w;
                    end
                endcase
                gpr[REG_ZERO] = '0;
                if (ev == EV_EXIT || ev == EV_BAD_SYSCALL || ev == EV_BAD_INSTR) begin
                    halted = 1'b1;
                end else if (pc >= prog_len) begin
                    halted = 1'b1;
                    if (ev == EV_NONE) ev = EV_PAST_END;
                end
            end
            exp.event_res   = ev;
            exp.event_value = val;
            exp.counter_out = pc;
            pending_events.push_back(exp);
            return ev;
        endfunction

        function void check_result(out_item_t got);
            out_item_t exp;
            if (pending_events.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: event %0d value %h counter %h",
                             got.event_res, got.event_value, got.counter_out);
                return;
            end
            exp = pending_events.pop_front();
            if (got.event_res !== exp.event_res || got.event_value !== exp.event_value ||
                got.counter_out !== exp.counter_out) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: event %0d/%0d value %h/%h counter %h/%h (exp/got)",
                             exp.event_res, got.event_res, exp.event_value,
                             got.event_value, exp.counter_out, got.counter_out);
            end
        endfunction
    endclass

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    in_item_t    s_payload = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    out_item_t   m_payload;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;

    event_scoreboard sb = new();

    int send_idle  = 0;
    int recv_stall = 0;
    int hold_req   = 0;
    int hold_left  = 0;
    int work_done  = 0;

    mips_subset_executor uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #5 aclk = ~aclk;

    always @(negedge aclk) begin
        if (hold_req != 0) begin
            hold_left = 150;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready === 1'b1) sb.check_result(m_payload);
    end

    function automatic logic [31:0] i_word(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                           logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    function automatic logic [31:0] r_word(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                                           logic [4:0] sh, logic [5:0] fn);
        return {OP_RTYPE, rs, rt, rd, sh, fn};
    endfunction

    function automatic logic [4:0] pick_reg();
        if ($urandom_range(9) < 7) return 5'($urandom_range(7));
        return 5'($urandom_range(31));
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(input in_item_t it);
        if ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(negedge aclk);
            while ($urandom_range(99) < send_idle) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= it;
        do @(posedge aclk); while (s_ready !== 1'b1);
        if (sb.note_item(it) != EV_HALTED) work_done++;
        @(negedge aclk);
    endtask

    task automatic send_exec(input logic [31:0] w);
        in_item_t it;
        it.opcode           = ITEM_EXEC;
        it.instruction_word = w;
        send_item(it);
    endtask

    task automatic send_start();
        in_item_t it;
        it.opcode           = ITEM_START;
        it.instruction_word = $urandom;
        send_item(it);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (sb.pending_events.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic apb_write(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        sb.write_cfg(idx, value);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_program(input logic [31:0] entry, input logic [31:0] len);
        wait_drained();
        apb_write(CFG_ENTRY, entry);
        apb_write(CFG_LENGTH, len);
    endtask

    task automatic run_directed();
        send_exec($urandom);
        send_start();
        set_program(32'd5, 32'd40);
        send_start();
        send_exec(i_word(OP_LUI, 5'd0, REG_A0, 16'h8000));
        send_exec(i_word(OP_ORI, REG_A0, REG_A0, 16'hFFFF));
        send_exec(i_word(OP_ADDI, REG_ZERO, REG_V0, 16'(SYS_PRINT_INT)));
        send_exec(r_word(5'd0, 5'd0, 5'd0, 5'd0, FN_SYSCALL));
        send_exec(i_word(OP_ADDI, REG_ZERO, REG_V0, 16'(SYS_PRINT_CHAR)));
        send_exec(i_word(OP_ADDI, REG_A0, REG_A0, 16'h8041));
        send_exec(r_word(5'd31, 5'd31, 5'd31, 5'd31, FN_SYSCALL));
        send_exec(r_word(REG_A0, REG_A0, REG_ZERO, 5'd0, FN_ADD));
        send_exec(r_word(REG_A0, REG_A0, 5'd31, 5'd0, FN_ADD));
        send_exec(i_word(OP_ADDI, REG_ZERO, REG_V0, 16'hFFFF));
        send_exec(r_word(5'd0, 5'd0, 5'd0, 5'd0, FN_SYSCALL));
        send_exec(i_word(OP_ADDI, REG_ZERO, 5'd1, 16'h7FFF));
        send_start();
        send_exec(32'hFFFF_FFFF);
        send_start();
        send_exec(r_word(5'd1, 5'd2, 5'd3, 5'd0, 6'h3F));
        send_start();
        send_exec(i_word(OP_ADDI, REG_ZERO, REG_V0, 16'(SYS_EXIT)));
        send_exec(r_word(5'd0, 5'd0, 5'd0, 5'd0, FN_SYSCALL));
        set_program(32'hFFFF_FFFE, 32'hFFFF_FFFF);
        send_start();
        send_exec(i_word(OP_ADDI, 5'd3, 5'd3, 16'h0001));
        set_program(32'd3, 32'd5);
        send_start();
        send_exec(i_word(OP_ADDI, REG_ZERO, REG_V0, 16'(SYS_PRINT_INT)));
        send_exec(r_word(5'd0, 5'd0, 5'd0, 5'd0, FN_SYSCALL));
        send_exec(i_word(OP_LUI, 5'd0, 5'd6, 16'h1234));
        set_program(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_start();
    endtask

    task automatic run_program(input int n_exec);
        int          k;
        int          sel;
        logic [15:0] num;
        send_start();
        for (k = 0; k < n_exec; k++) begin
            if (sb.halted) begin
                if ($urandom_range(3) == 0) send_exec($urandom);
                break;
            end
            sel = $urandom_range(99);
            if (sel < 20) begin
                send_exec(i_word(OP_ADDI, pick_reg(), pick_reg(), 16'($urandom)));
            end else if (sel < 32) begin
                send_exec(i_word(OP_ORI, pick_reg(), pick_reg(), 16'($urandom)));
            end else if (sel < 42) begin
                send_exec(i_word(OP_LUI, 5'($urandom), pick_reg(), 16'($urandom)));
            end else if (sel < 56) begin
                send_exec(r_word(pick_reg(), pick_reg(), pick_reg(), 5'($urandom), FN_ADD));
            end else if (sel < 76) begin
                case ($urandom_range(5))
                    0, 1:    num = 16'(SYS_PRINT_INT);
                    2, 3:    num = 16'(SYS_PRINT_CHAR);
                    4:       num = 16'(SYS_EXIT);
                    default: num = 16'($urandom);
                endcase
                send_exec(i_word(OP_ADDI, REG_ZERO, REG_V0, num));
                if (!sb.halted)
                    send_exec(r_word(5'($urandom), 5'($urandom), 5'($urandom),
                                     5'($urandom), FN_SYSCALL));
            end else if (sel < 82) begin
                send_exec(r_word(5'($urandom), 5'($urandom), 5'($urandom),
                                 5'($urandom), FN_SYSCALL));
            end else if (sel < 87) begin
                send_exec(r_word(5'($urandom), 5'($urandom), 5'($urandom),
                                 5'($urandom), 6'($urandom)));
            end else begin
                send_exec($urandom);
            end
        end
    endtask

    task automatic run_phase(input int s_idle, input int r_stall, input logic [31:0] entry,
                             input logic [31:0] len, input int target, input bit hold);
        int goal;
        set_program(entry, len);
        send_idle  = s_idle;
        recv_stall = r_stall;
        goal       = work_done + target;
        if (hold) hold_req = 1;
        while (work_done < goal) run_program($urandom_range(5, 70));
    endtask

    function automatic logic [31:0] near_len(logic [31:0] entry);
        return entry + 32'($urandom_range(0, 80));
    endfunction

    initial begin
        logic [31:0] e;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        run_directed();
        run_phase(0, 0, 32'd0, 32'hFFFF_FFFF, 220, 1'b1);
        e = $urandom_range(0, 30);
        run_phase(84, 0, e, near_len(e), 210, 1'b0);
        e = $urandom_range(0, 30);
        run_phase(0, 84, e, near_len(e), 210, 1'b0);
        e = $urandom_range(0, 30);
        run_phase(13, 13, e, near_len(e), 210, 1'b1);
        run_phase(0, 0, 32'hFFFF_FF00, 32'hFFFF_FF30, 210, 1'b0);
        e = $urandom;
        run_phase(84, 0, e, near_len(e), 210, 1'b0);
        e = $urandom_range(0, 30);
        run_phase(0, 84, e, near_len(e), 210, 1'b0);
        e = $urandom_range(0, 30);
        run_phase(13, 13, e, near_len(e), 210, 1'b0);
        wait_drained();
        repeat (10) @(negedge aclk);
        if (sb.mismatches == 0 && sb.pending_events.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("tb: failure");
        $finish;
    end

endmodule

[mips_subset_executor.f]
design/mse_pkg.sv
design/mse_ram.sv
design/mips_subset_executor.sv
test/mips_subset_executor_test.sv
